>>> src/dps_pkg.sv
// Shared types, constants and the twiddle ROM for the DFT power spectrum unit.
// No dependencies; used by every module in src except dps_ram.
`default_nettype none

package dps_pkg;

   // Fixed field widths of the channels
   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 3;
   localparam int BIN_W    = 6;
   localparam int PART_W   = 23;
   localparam int POWER_W  = 43;

   // Twiddle format and phase resolution (64 steps per turn)
   localparam int TW_W    = 16;
   localparam int FRAC_W  = 15;
   localparam int PHASE_W = 6;

   // Parameter defaults
   localparam int MAX_POINTS_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic [CFG_W-1:0]   LOG2_RESET = 3'd6;
   // sine is the cosine advanced by three quarter turns
   localparam logic [PHASE_W-1:0] SIN_OFFSET = 6'd48;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic               wr_en;
      logic [PHASE_W-1:0] wr_addr;
      logic               rd_en;
      logic [PHASE_W-1:0] rd_addr;
      logic               clear;
      logic [PHASE_W-1:0] step;
      logic               round;
      logic               square;
      logic               load_out;
      logic [BIN_W-1:0]   bin;
      logic               last;
   } dps_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pipe_empty;
      logic rsp_taken;
   } dps_status_type;

   // First quadrant of the Q1.15 cosine, entries 0 to 16 of 64 per turn
   function automatic logic signed [TW_W-1:0] cos_quarter(input logic [4:0] idx);
      logic signed [TW_W-1:0] q;
      case (idx)
         5'd0:    q = 16'sd32767;
         5'd1:    q = 16'sd32610;
         5'd2:    q = 16'sd32138;
         5'd3:    q = 16'sd31357;
         5'd4:    q = 16'sd30274;
         5'd5:    q = 16'sd28899;
         5'd6:    q = 16'sd27246;
         5'd7:    q = 16'sd25330;
         5'd8:    q = 16'sd23170;
         5'd9:    q = 16'sd20788;
         5'd10:   q = 16'sd18205;
         5'd11:   q = 16'sd15447;
         5'd12:   q = 16'sd12540;
         5'd13:   q = 16'sd9512;
         5'd14:   q = 16'sd6393;
         5'd15:   q = 16'sd3212;
         default: q = 16'sd0;
      endcase
      return q;
   endfunction

   // Full-turn cosine built from the quadrant by symmetry
   function automatic logic signed [TW_W-1:0] cos64(input logic [PHASE_W-1:0] m);
      logic [4:0]             r;
      logic [4:0]             idx;
      logic                   mirror;
      logic signed [TW_W-1:0] q;
      logic signed [TW_W-1:0] v;
      r      = m[4:0];
      mirror = (r > 5'd16);
      idx    = mirror ? 5'(6'd32 - {1'b0, r}) : r;
      q      = cos_quarter(idx);
      v      = mirror ? -q : q;
      return m[5] ? -v : v;
   endfunction

endpackage

`default_nettype wire

>>> src/dft_power_spectrum_unit.sv
// Top level of the direct-DFT power spectrum unit.
// Depends on dps_pkg, dps_ctrl, dps_datapath (and dps_ram below it).
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      sample
//   rsp_      out        valid / stall      bin_index, real_part, imag_part, power, last_bin
//   csr_      in         valid / ready      log2_points
//
// Samples are taken one per cycle while the frame fills and no length write is offered (N = 2^log2_points).
// After the last sample each bin runs one shared complex MAC over N terms,
// then drains the pipe, rounds, squares and loads the output register; the next
// bin starts only after rsp_ has taken that result.
// Inputs are taken only while filling; req_stall is also high while csr_valid is.
// Reset is synchronous; the frame store is not cleared and needs no clearing pass.
`default_nettype none

module dft_power_spectrum_unit #(
   parameter int MAX_POINTS  = dps_pkg::MAX_POINTS_DEF,
   parameter int SAMPLE_BITS = dps_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [dps_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic        [dps_pkg::BIN_W-1:0]         rsp_bin_index,
   output logic signed [dps_pkg::PART_W-1:0]        rsp_real_part,
   output logic signed [dps_pkg::PART_W-1:0]        rsp_imag_part,
   output logic        [dps_pkg::POWER_W-1:0]       rsp_power,
   output logic                                     rsp_last_bin,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [dps_pkg::CFG_W-1:0]    csr_log2_points
);
   import dps_pkg::*;

   dps_cmd_type    cmd;
   dps_status_type status;

   dps_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_log2_points(csr_log2_points),
      .cmd            (cmd),
      .status         (status)
   );

   dps_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_bin_index(rsp_bin_index),
      .rsp_real_part(rsp_real_part),
      .rsp_imag_part(rsp_imag_part),
      .rsp_power    (rsp_power),
      .rsp_last_bin (rsp_last_bin)
   );

endmodule

`default_nettype wire

>>> src/dps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/dps_ctrl.sv
// Controller for the DFT power spectrum unit: frame fill, bin and term sequencing.
// Depends on dps_pkg for the command and status structs.
`default_nettype none

module dps_ctrl #(
   parameter int MAX_POINTS = dps_pkg::MAX_POINTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [dps_pkg::CFG_W-1:0]  csr_log2_points,
   output dps_pkg::dps_cmd_type            cmd,
   input  wire dps_pkg::dps_status_type    status
);
   import dps_pkg::*;

   localparam int LOG2_MAX = $clog2(MAX_POINTS + 1) - 1;
   localparam int IDX_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   typedef enum logic [2:0] {
      S_FILL,
      S_START,
      S_MAC,
      S_DRAIN,
      S_ROUND,
      S_SQUARE,
      S_LOAD,
      S_WAIT
   } state_type;

   state_type          state_ff;
   logic [CFG_W-1:0]   log2_ff;
   logic [IDX_W-1:0]   fill_ff;
   logic [IDX_W-1:0]   term_ff;
   logic [IDX_W-1:0]   bin_ff;

   logic [CFG_W-1:0]   eff_log2;
   logic [IDX_W-1:0]   last_idx;
   logic               req_xfer;
   logic               csr_xfer;

   // Effective length: register clipped to what the store can hold
   assign eff_log2 = (log2_ff < CFG_W'(LOG2_MAX)) ? log2_ff : CFG_W'(LOG2_MAX);
   assign last_idx = IDX_W'((7'd1 << eff_log2) - 7'd1);

   // Hold samples back while a length write is offered, so the two never share an edge
   assign req_stall = (state_ff != S_FILL) || csr_valid;
   assign csr_ready = (state_ff == S_FILL);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_xfer  = csr_valid && csr_ready;

   // Commands decoded from state and counters
   always_comb begin
      cmd          = '0;
      cmd.wr_en    = req_xfer;
      cmd.wr_addr  = PHASE_W'(fill_ff);
      cmd.rd_en    = (state_ff == S_MAC);
      cmd.rd_addr  = PHASE_W'(term_ff);
      cmd.clear    = (state_ff == S_START);
      cmd.step     = PHASE_W'(PHASE_W'(bin_ff) << (CFG_W'(PHASE_W) - eff_log2));
      cmd.round    = (state_ff == S_ROUND);
      cmd.square   = (state_ff == S_SQUARE);
      cmd.load_out = (state_ff == S_LOAD);
      cmd.bin      = BIN_W'(bin_ff);
      cmd.last     = (bin_ff == last_idx);
   end

   // State, length register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         log2_ff  <= LOG2_RESET;
         fill_ff  <= '0;
         term_ff  <= '0;
         bin_ff   <= '0;
      end else begin
         case (state_ff)
            S_FILL: begin
               if (csr_xfer) begin
                  // a new length drops the part-filled frame
                  log2_ff <= csr_log2_points;
                  fill_ff <= '0;
               end else if (req_xfer) begin
                  if (fill_ff == last_idx) begin
                     fill_ff  <= '0;
                     bin_ff   <= '0;
                     state_ff <= S_START;
                  end else begin
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
            end
            S_START: begin
               term_ff  <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               if (term_ff == last_idx) begin
                  state_ff <= S_DRAIN;
               end else begin
                  term_ff <= term_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               if (status.pipe_empty) begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND:  state_ff <= S_SQUARE;
            S_SQUARE: state_ff <= S_LOAD;
            S_LOAD:   state_ff <= S_WAIT;
            S_WAIT: begin
               if (status.rsp_taken) begin
                  if (bin_ff == last_idx) begin
                     state_ff <= S_FILL;
                  end else begin
                     bin_ff   <= bin_ff + 1'b1;
                     state_ff <= S_START;
                  end
               end
            end
            default: state_ff <= S_FILL;
         endcase
      end
   end

`ifndef SYNTHESIS
   // Term counter never runs past the frame
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (term_ff <= last_idx))
      else $error("term counter beyond frame length");

   // Results are loaded only once the accumulation pipe has drained
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.pipe_empty)
      else $error("result loaded with products still in flight");

   // Transfer of the final bin returns to filling an empty frame
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && status.rsp_taken && bin_ff == last_idx)
      |=> (state_ff == S_FILL && fill_ff == '0))
      else $error("frame did not restart after last bin");
`endif

endmodule

`default_nettype wire

>>> src/dps_datapath.sv
// Datapath for the DFT power spectrum unit: frame store, complex MAC, rounding,
// power and output register. Depends on dps_pkg and dps_ram.
`default_nettype none

module dps_datapath #(
   parameter int MAX_POINTS  = dps_pkg::MAX_POINTS_DEF,
   parameter int SAMPLE_BITS = dps_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dps_pkg::dps_cmd_type               cmd,
   output dps_pkg::dps_status_type                 status,
   input  wire logic signed [dps_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic        [dps_pkg::BIN_W-1:0]        rsp_bin_index,
   output logic signed [dps_pkg::PART_W-1:0]       rsp_real_part,
   output logic signed [dps_pkg::PART_W-1:0]       rsp_imag_part,
   output logic        [dps_pkg::POWER_W-1:0]      rsp_power,
   output logic                                    rsp_last_bin
);
   import dps_pkg::*;

   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PROD_W = SAMPLE_BITS + TW_W;
   localparam int ACC_W  = PROD_W + PHASE_W;
   localparam int SQ_W   = 2 * PART_W;

   localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(2 ** (FRAC_W - 1));
   localparam logic signed [ACC_W:0] PART_MAX = (ACC_W + 1)'(2 ** (PART_W - 1) - 1);
   localparam logic signed [ACC_W:0] PART_MIN = -(ACC_W + 1)'(2 ** (PART_W - 1));
   localparam logic [SQ_W:0]         POWER_MAX = (SQ_W + 1)'({POWER_W{1'b1}});

   logic [SAMPLE_BITS-1:0]        wr_data;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] x_sample;

   logic [PHASE_W-1:0]            phase_ff;
   logic signed [TW_W-1:0]        cos_ff;
   logic signed [TW_W-1:0]        sin_ff;
   logic                          v1_ff;
   logic signed [PROD_W-1:0]      prod_re_ff;
   logic signed [PROD_W-1:0]      prod_im_ff;
   logic                          v2_ff;
   logic signed [ACC_W-1:0]       re_acc_ff;
   logic signed [ACC_W-1:0]       im_acc_ff;

   logic signed [ACC_W:0]         re_shift;
   logic signed [ACC_W:0]         im_shift;
   logic signed [PART_W-1:0]      re_q_ff;
   logic signed [PART_W-1:0]      im_q_ff;
   logic signed [SQ_W-1:0]        re_sq_ff;
   logic signed [SQ_W-1:0]        im_sq_ff;
   logic [SQ_W:0]                 pw_sum;

   logic                          rsp_valid_ff;
   logic [BIN_W-1:0]              rsp_bin_ff;
   logic signed [PART_W-1:0]      rsp_re_ff;
   logic signed [PART_W-1:0]      rsp_im_ff;
   logic [POWER_W-1:0]            rsp_pw_ff;
   logic                          rsp_last_ff;

   // Take the low sample bits, or widen when the store is wider than the port
   generate
      if (SAMPLE_BITS <= SAMPLE_W) begin : g_narrow
         assign wr_data = req_sample[SAMPLE_BITS-1:0];
      end else begin : g_wide
         assign wr_data = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, req_sample};
      end
   endgenerate

   dps_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_POINTS),
      .ADDR_W(IDX_W)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(IDX_W'(cmd.wr_addr)),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(IDX_W'(cmd.rd_addr)),
      .rd_data(rd_data)
   );

   assign x_sample = $signed(rd_data);

   // Saturate a rounded part to the result range
   function automatic logic signed [PART_W-1:0] sat_part(input logic signed [ACC_W:0] v);
      logic signed [ACC_W:0] c;
      c = (v > PART_MAX) ? PART_MAX : ((v < PART_MIN) ? PART_MIN : v);
      return PART_W'(c);
   endfunction

   // Phase walk and twiddle lookup alongside the store read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         phase_ff <= '0;
      end else if (cmd.rd_en) begin
         phase_ff <= phase_ff + cmd.step;
      end
      if (cmd.rd_en) begin
         cos_ff <= cos64(phase_ff);
         sin_ff <= cos64(phase_ff + SIN_OFFSET);
      end
   end

   // Products, then accumulation: real adds, imaginary subtracts
   always_ff @(posedge clock) begin
      prod_re_ff <= x_sample * cos_ff;
      prod_im_ff <= x_sample * sin_ff;
      if (cmd.clear) begin
         re_acc_ff <= '0;
         im_acc_ff <= '0;
      end else if (v2_ff) begin
         re_acc_ff <= re_acc_ff + ACC_W'(prod_re_ff);
         im_acc_ff <= im_acc_ff - ACC_W'(prod_im_ff);
      end
   end

   // Pipe valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
      end
   end

   assign status.pipe_empty = !v1_ff && !v2_ff;

   // Round to nearest, ties upward: floor((s + 2^14) / 2^15)
   assign re_shift = ((ACC_W + 1)'(re_acc_ff) + RND_HALF) >>> FRAC_W;
   assign im_shift = ((ACC_W + 1)'(im_acc_ff) + RND_HALF) >>> FRAC_W;

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         re_q_ff <= sat_part(re_shift);
         im_q_ff <= sat_part(im_shift);
      end
      if (cmd.square) begin
         re_sq_ff <= re_q_ff * re_q_ff;
         im_sq_ff <= im_q_ff * im_q_ff;
      end
   end

   assign pw_sum = {1'b0, re_sq_ff} + {1'b0, im_sq_ff};

   // Output register: load one bin, hold until transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_bin_ff  <= cmd.bin;
         rsp_re_ff   <= re_q_ff;
         rsp_im_ff   <= im_q_ff;
         rsp_pw_ff   <= (pw_sum > POWER_MAX) ? {POWER_W{1'b1}} : POWER_W'(pw_sum);
         rsp_last_ff <= cmd.last;
      end
   end

   assign status.rsp_taken = rsp_valid_ff && !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;
   assign rsp_real_part = rsp_re_ff;
   assign rsp_imag_part = rsp_im_ff;
   assign rsp_power     = rsp_pw_ff;
   assign rsp_last_bin  = rsp_last_ff;

`ifndef SYNTHESIS
   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid_ff)
      else $error("result register overwritten before transfer");

   // Every twiddled sample reaches the product stage
   assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff)
      else $error("product stage lost a term");

   // Power is zero exactly when both parts are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_pw_ff == '0) == (rsp_re_ff == '0 && rsp_im_ff == '0)))
      else $error("power disagrees with its parts");
`endif

endmodule

`default_nettype wire
